// File: src/topic_wildcard_matcher_unit_macros.svh
// Assertion macros for the topic wildcard matcher.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef TOPIC_WILDCARD_MATCHER_UNIT_MACROS_SVH
`define TOPIC_WILDCARD_MATCHER_UNIT_MACROS_SVH

// same-cycle implication
`define TWM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TWM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/twm_pkg.sv
// Shared constants and types for the topic wildcard matcher.
// No dependencies.
package twm_pkg;

  localparam int MAX_TOPIC_LEN_DEF = 64;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_STAR  = 8'h2A;

  localparam logic MODE_TOPIC   = 1'b0;
  localparam logic MODE_PATTERN = 1'b1;

  typedef struct packed {
    logic miss;
    logic star;
    logic plus;
  } seg_kind_t;

endpackage

// File: src/topic_wildcard_matcher_unit.sv
// Topic wildcard matcher: topic store, segment-end store and pattern matcher.
// Depends on twm_pkg and topic_wildcard_matcher_unit_macros.svh.
//
//  channel | dir | handshake          | payload
//  s_*     | in  | s_tvalid/s_tready  | tdata: char_code; tlast: last_byte;
//          |     |                    | tuser: mode, empty_req
//  m_*     | out | m_tvalid/m_tready  | tdata: matched, too_long, zero fill
//
// One word per cycle on the slave side while s_tready is high; each pattern
// word does a single compare-and-advance against the character and segment-end
// memories, whose registered reads are addressed from the next state.
// Results appear in the cycle after the final pattern word is accepted.
// Reset is synchronous; the stores need no clearing pass.
// s_tready drops only while a result waits and m_tready is low.
`include "topic_wildcard_matcher_unit_macros.svh"

module topic_wildcard_matcher_unit #(
  parameter int MAX_TOPIC_LEN = twm_pkg::MAX_TOPIC_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_code
  input  logic       s_tlast,
  input  logic [1:0] s_tuser,   // [0] mode, [1] empty_req
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] matched, [1] too_long, [7:2] zero
);
  import twm_pkg::*;

  localparam int AW = $clog2(MAX_TOPIC_LEN);
  localparam int CW = $clog2(MAX_TOPIC_LEN + 2);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_TOPIC_LEN);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  logic [7:0]    char_mem [MAX_TOPIC_LEN];
  logic [AW-1:0] seg_mem  [MAX_TOPIC_LEN];

  logic [CW-1:0] topic_length, topic_length_next;
  logic [CW-1:0] topic_slashes, topic_slashes_next;
  logic          topic_overflow, topic_overflow_next;
  logic          topic_open, topic_open_next;
  logic [CW-1:0] topic_position, topic_position_next;
  logic [CW-1:0] pat_seg, pat_seg_next;
  logic          match_so_far, match_so_far_next;
  seg_kind_t     kind, kind_next;
  logic [1:0]    seg_len, seg_len_next;
  logic          out_valid, out_valid_next;
  logic          matched, matched_next;
  logic          too_long, too_long_next;

  logic [7:0]    char_rd;
  logic [AW-1:0] seg_rd0, seg_rd1;

  logic          in_acc, mode, empty;
  logic [7:0]    ch;
  logic          cw_en, sw_en;
  logic [AW-1:0] cw_addr, sw_addr, sw_data;
  logic [CW-1:0] len_eff, sl_eff;
  logic [AW-1:0] rd_pos, rd_seg0, rd_seg1;
  logic [CW-1:0] seg_next_p1;

  logic [CW-1:0] seg_end_cur, seg_end_nxt, pat_seg_p1;
  logic          in_range, seg_ok_cur, adv;
  logic [CW-1:0] a_pos, a_seg, a_seg_end;
  logic          a_match, a_ok, a_star;
  seg_kind_t     a_kind;
  logic [1:0]    a_len;
  logic          result;

  assign in_acc   = s_tvalid && s_tready;
  assign s_tready = !out_valid || m_tready;
  assign mode     = s_tuser[0];
  assign empty    = s_tuser[1];
  assign ch       = s_tdata;
  assign m_tvalid = out_valid;
  assign m_tdata  = {6'b0, too_long, matched};

  // Segment bounds for the current and following pattern segment
  assign pat_seg_p1  = pat_seg + ONE_C;
  assign in_range    = pat_seg <= topic_slashes;
  assign seg_end_cur = (pat_seg < topic_slashes) ? CW'(seg_rd0) : topic_length;
  assign seg_end_nxt = (pat_seg_p1 < topic_slashes) ? CW'(seg_rd1) : topic_length;
  assign seg_ok_cur  = in_range && ((kind.plus && seg_len == 2'd1) ||
                       (!kind.miss && topic_position == seg_end_cur));
  assign adv = in_range && (topic_position < seg_end_cur) && (topic_position < MAX_C) &&
               (char_rd == ch);

  // Pattern state after this word's character, if any
  always_comb begin
    a_pos     = topic_position;
    a_seg     = pat_seg;
    a_seg_end = seg_end_cur;
    a_match   = match_so_far;
    a_kind    = kind;
    a_len     = seg_len;
    if (!empty) begin
      if (ch == CH_SLASH) begin
        a_match = match_so_far && seg_ok_cur;
        if (in_range) begin
          a_pos     = seg_end_cur + ONE_C;
          a_seg     = pat_seg_p1;
          a_seg_end = seg_end_nxt;
        end
        a_kind = '0;
        a_len  = 2'd0;
      end else begin
        if (seg_len == 2'd0) begin
          a_kind.plus = kind.plus | (ch == CH_PLUS);
          a_kind.star = kind.star | (ch == CH_STAR);
        end
        a_kind.miss = kind.miss | !adv;
        if (adv) a_pos = topic_position + ONE_C;
        a_len = (seg_len == 2'd2) ? 2'd2 : seg_len + 2'd1;
      end
    end
    a_ok   = (a_seg <= topic_slashes) && ((a_kind.plus && a_len == 2'd1) ||
             (!a_kind.miss && a_pos == a_seg_end));
    a_star = a_kind.star && a_len == 2'd1;
    if (topic_overflow)
      result = 1'b0;
    else if (a_star)
      result = a_match;
    else
      result = a_match && (a_seg == topic_slashes) && a_ok;
  end

  always_comb begin
    topic_length_next   = topic_length;
    topic_slashes_next  = topic_slashes;
    topic_overflow_next = topic_overflow;
    topic_open_next     = topic_open;
    topic_position_next = topic_position;
    pat_seg_next        = pat_seg;
    match_so_far_next   = match_so_far;
    kind_next           = kind;
    seg_len_next        = seg_len;
    matched_next        = matched;
    too_long_next       = too_long;
    out_valid_next      = out_valid && !m_tready;
    len_eff             = topic_open ? topic_length : '0;
    sl_eff              = topic_open ? topic_slashes : '0;
    cw_en               = 1'b0;
    sw_en               = 1'b0;
    cw_addr             = len_eff[AW-1:0];
    sw_addr             = sl_eff[AW-1:0];
    sw_data             = len_eff[AW-1:0];
    if (in_acc) begin
      if (mode == MODE_TOPIC) begin
        topic_position_next = '0;
        pat_seg_next        = '0;
        match_so_far_next   = 1'b1;
        kind_next           = '0;
        seg_len_next        = 2'd0;
        topic_open_next     = !empty && !s_tlast;
        topic_length_next   = len_eff;
        topic_slashes_next  = sl_eff;
        if (!topic_open) topic_overflow_next = 1'b0;
        if (!empty) begin
          if (len_eff < MAX_C) begin
            cw_en             = 1'b1;
            topic_length_next = len_eff + ONE_C;
            if (ch == CH_SLASH) begin
              sw_en              = 1'b1;
              topic_slashes_next = sl_eff + ONE_C;
            end
          end else begin
            topic_overflow_next = 1'b1;
          end
        end
      end else begin
        topic_open_next = 1'b0;
        if (empty || s_tlast) begin
          topic_position_next = '0;
          pat_seg_next        = '0;
          match_so_far_next   = 1'b1;
          kind_next           = '0;
          seg_len_next        = 2'd0;
          out_valid_next      = 1'b1;
          matched_next        = result;
          too_long_next       = topic_overflow;
        end else begin
          topic_position_next = a_pos;
          pat_seg_next        = a_seg;
          match_so_far_next   = a_match;
          kind_next           = a_kind;
          seg_len_next        = a_len;
        end
      end
    end
  end

  // Read addresses follow the next state so data lines up with the next word
  assign seg_next_p1 = pat_seg_next + ONE_C;
  assign rd_pos      = topic_position_next[AW-1:0];
  assign rd_seg0     = pat_seg_next[AW-1:0];
  assign rd_seg1     = seg_next_p1[AW-1:0];

  always_ff @(posedge clk) begin
    if (cw_en) char_mem[cw_addr] <= ch;
    char_rd <= (cw_en && cw_addr == rd_pos) ? ch : char_mem[rd_pos];
  end

  always_ff @(posedge clk) begin
    if (sw_en) seg_mem[sw_addr] <= sw_data;
    seg_rd0 <= (sw_en && sw_addr == rd_seg0) ? sw_data : seg_mem[rd_seg0];
    seg_rd1 <= (sw_en && sw_addr == rd_seg1) ? sw_data : seg_mem[rd_seg1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      topic_length   <= '0;
      topic_slashes  <= '0;
      topic_overflow <= 1'b0;
      topic_open     <= 1'b0;
      topic_position <= '0;
      pat_seg        <= '0;
      match_so_far   <= 1'b1;
      kind           <= '0;
      seg_len        <= 2'd0;
      out_valid      <= 1'b0;
    end else begin
      topic_length   <= topic_length_next;
      topic_slashes  <= topic_slashes_next;
      topic_overflow <= topic_overflow_next;
      topic_open     <= topic_open_next;
      topic_position <= topic_position_next;
      pat_seg        <= pat_seg_next;
      match_so_far   <= match_so_far_next;
      kind           <= kind_next;
      seg_len        <= seg_len_next;
      out_valid      <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    matched  <= matched_next;
    too_long <= too_long_next;
  end

  `TWM_ASSERT_NOW(a_overflow_never_matches, out_valid && too_long, !matched, "overflowed topic matched")
  `TWM_ASSERT_NOW(a_overflow_full, topic_overflow, topic_length == MAX_C, "overflow below full length")
  `TWM_ASSERT_NOW(a_slashes_bounded, 1'b1, topic_slashes <= topic_length, "more slashes than bytes")
  `TWM_ASSERT_NEXT(a_topic_clears_pattern, in_acc && mode == MODE_TOPIC, topic_position == '0 && pat_seg == '0 && match_so_far, "pattern state not cleared")

endmodule

// File: test/topic_wildcard_matcher_unit_tb.sv
// Self-checking testbench for topic_wildcard_matcher_unit: topics and patterns go in as
// stream words, and every match result is checked against a behavioural model of the matcher.
// Depends on twm_pkg and the matcher RTL; needs no files or arguments.
module topic_wildcard_matcher_unit_tb;
  import twm_pkg::*;

  localparam int TOPIC_CAP   = MAX_TOPIC_LEN_DEF;
  localparam int WORD_TARGET = 1100;
  localparam int QUIET_LIMIT = 2000;
  localparam int MAX_WAIT    = 19;
  localparam int PRINT_CAP   = 40;
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_Z = 8'h7A;

  typedef struct packed {
    logic       mode;
    logic [7:0] code;
    logic       last;
    logic       empty;
  } in_word_t;

  typedef struct packed {
    logic matched;
    logic too_long;
  } verdict_t;

  typedef logic [7:0] byte_q_t [$];
  typedef enum logic [1:0] {SEG_COPY, SEG_PLUS, SEG_ALTER} seg_plan_t;
  typedef enum logic [1:0] {END_LAST, END_EMPTY, END_OPEN} str_end_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] char_code
  logic       s_tlast;
  logic [1:0] s_tuser;   // [0] mode, [1] empty_req
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [0] matched, [1] too_long, [7:2] zero

  topic_wildcard_matcher_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  in_word_t stim_words [$];
  verdict_t due_verdicts [$];
  byte_q_t  gen_topic;

  int errors     = 0;
  int n_words    = 0;
  int n_verdicts = 0;
  int n_hits     = 0;
  int n_long     = 0;
  int quiet      = 0;

  // matcher model state
  logic [7:0] t_chars [TOPIC_CAP];
  logic [6:0] slash_at [TOPIC_CAP];
  logic [6:0] t_len, t_slashes, t_pos, p_seg;
  logic       t_ovf, t_open, p_open, still_ok;
  seg_kind_t  kind;
  logic [1:0] s_len;

  task automatic note_error(input string what, input int got, input int want);
    if (errors < PRINT_CAP)
      $display("ERROR @%0t: %s got %0d want %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic clear_pattern();
    p_open   = 1'b0;
    t_pos    = '0;
    p_seg    = '0;
    still_ok = 1'b1;
    kind     = '0;
    s_len    = '0;
  endtask

  task automatic reset_matcher();
    t_len     = '0;
    t_ovf     = 1'b0;
    t_slashes = '0;
    t_open    = 1'b0;
    clear_pattern();
  endtask

  // exclusive end of topic segment k
  function automatic logic [6:0] seg_limit(input logic [6:0] k);
    if (k < t_slashes)
      return slash_at[k[5:0]];
    return t_len;
  endfunction

  function automatic logic seg_fits();
    if (p_seg > t_slashes)
      return 1'b0;
    if (kind.plus && s_len == 2'd1)
      return 1'b1;
    return !kind.miss && t_pos == seg_limit(p_seg);
  endfunction

  task automatic pattern_char(input logic [7:0] c);
    if (c == CH_SLASH) begin
      if (!seg_fits())
        still_ok = 1'b0;
      if (p_seg <= t_slashes) begin
        t_pos = seg_limit(p_seg) + 7'd1;
        p_seg++;
      end
      kind  = '0;
      s_len = '0;
    end else begin
      if (s_len == 2'd0) begin
        if (c == CH_PLUS)
          kind.plus = 1'b1;
        if (c == CH_STAR)
          kind.star = 1'b1;
      end
      if (s_len < 2'd2)
        s_len++;
      if (p_seg <= t_slashes && t_pos < seg_limit(p_seg) && t_pos < TOPIC_CAP &&
          t_chars[t_pos[5:0]] == c)
        t_pos++;
      else
        kind.miss = 1'b1;
    end
  endtask

  task automatic step_matcher(input in_word_t w, output logic fired, output verdict_t v);
    logic star;
    fired = 1'b0;
    v     = '0;
    if (w.mode == MODE_TOPIC) begin
      if (p_open)
        clear_pattern();
      if (!t_open) begin
        t_len     = '0;
        t_ovf     = 1'b0;
        t_slashes = '0;
        t_open    = 1'b1;
      end
      if (w.empty) begin
        t_open = 1'b0;
      end else begin
        if (t_len < TOPIC_CAP) begin
          t_chars[t_len[5:0]] = w.code;
          if (w.code == CH_SLASH && t_slashes < TOPIC_CAP) begin
            slash_at[t_slashes[5:0]] = t_len;
            t_slashes++;
          end
          t_len++;
        end else begin
          t_ovf = 1'b1;
        end
        if (w.last)
          t_open = 1'b0;
      end
    end else begin
      t_open = 1'b0;
      p_open = 1'b1;
      if (!w.empty)
        pattern_char(w.code);
      if (w.empty || w.last) begin
        star  = kind.star && s_len == 2'd1;
        fired = 1'b1;
        if (t_ovf)
          v.matched = 1'b0;
        else if (star)
          v.matched = still_ok;
        else
          v.matched = still_ok && p_seg == t_slashes && seg_fits();
        v.too_long = t_ovf;
        clear_pattern();
      end
    end
  endtask

  // ---------------- stimulus generation
  task automatic push_word(input logic mode, input logic [7:0] code, input logic last,
                           input logic empty);
    in_word_t w;
    w.mode  = mode;
    w.code  = code;
    w.last  = last;
    w.empty = empty;
    stim_words.insert(stim_words.size(), w);
  endtask

  task automatic push_empty(input logic mode);
    push_word(mode, 8'($urandom_range(1, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  task automatic queue_bytes(input logic mode, input byte_q_t q, input str_end_t ending);
    if (q.size() == 0 && ending != END_OPEN) begin
      push_empty(mode);
    end else begin
      foreach (q[i])
        push_word(mode, q[i], ending == END_LAST && i == q.size() - 1, 1'b0);
      if (ending == END_EMPTY)
        push_empty(mode);
    end
  endtask

  task automatic queue_text(input logic mode, input string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++)
      q.insert(q.size(), 8'(s[i]));
    queue_bytes(mode, q, END_LAST);
  endtask

  task automatic queue_random_topic();
    int r, len, nseg;
    str_end_t ending;
    gen_topic.delete();
    if ($urandom_range(0, 11) == 0) begin
      // long topics straddle the store size
      len = $urandom_range(56, 72);
      for (int i = 0; i < len; i++)
        gen_topic.insert(gen_topic.size(),
                         ($urandom_range(0, 5) == 0) ? CH_SLASH
                                                     : CH_A + 8'($urandom_range(0, 2)));
    end else begin
      nseg = $urandom_range(1, 4);
      for (int s = 0; s < nseg; s++) begin
        if (s > 0)
          gen_topic.insert(gen_topic.size(), CH_SLASH);
        len = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 15);
          if (r == 0)
            gen_topic.insert(gen_topic.size(), CH_PLUS);
          else if (r == 1)
            gen_topic.insert(gen_topic.size(), CH_STAR);
          else if (r == 2)
            gen_topic.insert(gen_topic.size(), 8'($urandom_range(1, 255)));
          else
            gen_topic.insert(gen_topic.size(), CH_A + 8'($urandom_range(0, 2)));
        end
      end
    end
    r = $urandom_range(0, 15);
    ending = (r < 2) ? END_EMPTY : (r == 2) ? END_OPEN : END_LAST;
    queue_bytes(MODE_TOPIC, gen_topic, ending);
  endtask

  function automatic seg_plan_t pick_plan();
    int r;
    r = $urandom_range(0, 7);
    return (r < 5) ? SEG_COPY : (r < 7) ? SEG_PLUS : SEG_ALTER;
  endfunction

  task automatic close_seg(ref byte_q_t pat, input seg_plan_t plan);
    if (plan == SEG_PLUS) begin
      pat.insert(pat.size(), CH_PLUS);
      if ($urandom_range(0, 5) == 0)
        pat.insert(pat.size(), CH_A);
    end else if (plan == SEG_ALTER) begin
      if (pat.size() > 0 && pat[pat.size() - 1] != CH_SLASH && $urandom_range(0, 1) == 0)
        void'(pat.pop_back());
      else
        pat.insert(pat.size(), CH_Z);
    end
  endtask

  task automatic queue_random_pattern();
    byte_q_t   pat;
    seg_plan_t plan;
    int        nseg, keep, k, tail;
    str_end_t  ending;
    nseg = 1;
    foreach (gen_topic[i])
      if (gen_topic[i] == CH_SLASH)
        nseg++;
    keep = ($urandom_range(0, 3) == 0) ? $urandom_range(0, nseg + 1) : nseg;
    k    = 0;
    plan = pick_plan();
    foreach (gen_topic[i]) begin
      if (k < keep) begin
        if (gen_topic[i] == CH_SLASH) begin
          close_seg(pat, plan);
          k++;
          if (k < keep)
            pat.insert(pat.size(), CH_SLASH);
          plan = pick_plan();
        end else if (plan != SEG_PLUS) begin
          pat.insert(pat.size(), gen_topic[i]);
        end
      end
    end
    if (k < keep)
      close_seg(pat, plan);
    if (keep > nseg) begin
      pat.insert(pat.size(), CH_SLASH);
      pat.insert(pat.size(), CH_A);
    end
    tail = $urandom_range(0, 7);
    if (tail < 2) begin
      if (pat.size() > 0)
        pat.insert(pat.size(), CH_SLASH);
      pat.insert(pat.size(), CH_STAR);
    end else if (tail == 2) begin
      pat.insert(pat.size(), CH_STAR);
    end else if (tail == 3) begin
      pat.push_front(CH_SLASH);
      pat.push_front(CH_STAR);
    end
    if ($urandom_range(0, 15) == 0 && pat.size() > 0) begin
      // abandoned pattern, cut off by a new topic
      queue_bytes(MODE_PATTERN, pat, END_OPEN);
      queue_random_topic();
    end else begin
      ending = ($urandom_range(0, 7) == 0) ? END_EMPTY : END_LAST;
      queue_bytes(MODE_PATTERN, pat, ending);
    end
  endtask

  task automatic queue_noise();
    int n;
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++)
      push_word(1'($urandom_range(0, 1)), 8'($urandom_range(1, 255)),
                $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0);
  endtask

  // ---------------- driver
  in_word_t cur_word;
  int       hold;
  logic     fired;
  verdict_t got_v, want_v;
  int       stall;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tlast  <= 1'b0;
      s_tuser  <= '0;
      hold = 0;
      reset_matcher();
    end else begin
      if (s_tvalid && s_tready) begin
        step_matcher(cur_word, fired, got_v);
        if (fired)
          due_verdicts.insert(due_verdicts.size(), got_v);
        n_words++;
      end
      if (!s_tvalid || s_tready) begin
        if (hold > 0) begin
          s_tvalid <= 1'b0;
          hold--;
        end else if (stim_words.size() > 0) begin
          cur_word = stim_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= cur_word.code;
          s_tlast  <= cur_word.last;
          s_tuser  <= {cur_word.empty, cur_word.mode};
          hold = ((n_words / 150) % 4 == 3) ? 0 : $urandom_range(0, MAX_WAIT);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (due_verdicts.size() == 0) begin
          note_error("unexpected result word", int'(m_tdata), 0);
        end else begin
          want_v = due_verdicts.pop_front();
          if (m_tdata[0] !== want_v.matched)
            note_error("matched", int'(m_tdata[0]), int'(want_v.matched));
          if (m_tdata[1] !== want_v.too_long)
            note_error("too_long", int'(m_tdata[1]), int'(want_v.too_long));
          if (m_tdata[7:2] !== 6'd0)
            note_error("tdata fill", int'(m_tdata[7:2]), 0);
          n_hits += int'(want_v.matched);
          n_long += int'(want_v.too_long);
        end
        n_verdicts++;
        stall = ((n_verdicts / 40) % 4 == 1) ? 0 : $urandom_range(0, MAX_WAIT);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
  end

  initial begin
    rst = 1'b1;

    // empty topic after reset
    queue_text(MODE_PATTERN, "");
    queue_text(MODE_PATTERN, "*");
    queue_text(MODE_TOPIC, "a/b");
    queue_text(MODE_PATTERN, "+/b");
    queue_text(MODE_PATTERN, "a/*");
    queue_text(MODE_PATTERN, "*/b");
    // pattern closed by an empty word
    push_word(MODE_PATTERN, CH_A, 1'b0, 1'b0);
    push_empty(MODE_PATTERN);
    // pattern word closes an open topic
    push_word(MODE_TOPIC, 8'h01, 1'b0, 1'b0);
    push_word(MODE_PATTERN, 8'h01, 1'b1, 1'b0);
    // topic word drops an open pattern
    push_word(MODE_PATTERN, CH_Z, 1'b0, 1'b0);
    push_word(MODE_TOPIC, 8'hFF, 1'b1, 1'b0);
    push_word(MODE_PATTERN, 8'hFF, 1'b1, 1'b0);
    push_empty(MODE_TOPIC);
    queue_text(MODE_PATTERN, "+");
    queue_text(MODE_PATTERN, "+/+");

    gen_topic.delete();
    while (stim_words.size() < WORD_TARGET) begin
      case ($urandom_range(0, 99)) inside
        [0:14]:  queue_random_topic();
        [15:84]: queue_random_pattern();
        default: queue_noise();
      endcase
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do
      @(negedge clk);
    while (quiet < QUIET_LIMIT &&
           (stim_words.size() > 0 || s_tvalid || due_verdicts.size() > 0));
    if (quiet >= QUIET_LIMIT)
      note_error("watchdog: cycles without a handshake", quiet, QUIET_LIMIT);
    else
      repeat (8) @(negedge clk);
    if (due_verdicts.size() > 0)
      note_error("results never delivered", due_verdicts.size(), 0);

    $display("Sent %0d words; checked %0d results (%0d matches, %0d with too_long).",
             n_words, n_verdicts, n_hits, n_long);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
